### design/sha256_stream_hash_defines.svh
// assertion macros for the sha256 stream hash block
// no dependencies; taken in by modules that carry checks
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH
`ifndef SYNTHESIS
// check under reset gating
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/sha_pkg.sv
// types, constants and round helpers for the sha256 stream hash
// no dependencies
package sha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BYTES, ST_PAD, ST_ZERO, ST_LEN, ST_COMP, ST_UPD, ST_OUT
  } sha_state_t;

  typedef enum logic [1:0] {
    SRC_ITEM, SRC_PAD, SRC_ZERO, SRC_LEN
  } sha_src_t;

  // controller to datapath
  typedef struct packed {
    logic        load_item;
    logic        push;
    sha_src_t    src;
    logic [1:0]  item_pos;
    logic [2:0]  len_idx;
    logic        round;
    logic [5:0]  round_idx;
    logic        update;
    logic        clear;
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] nb;
    logic       eom;
  } sha_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### design/sha_dp.sv
// datapath: item capture, block shift line, schedule, rounds, hash state
// depends on sha_pkg
module sha_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::sha_in_t  in_data,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [2:0]        out_idx,
  output sha_pkg::sha_sts_t sts,
  output logic [31:0]       digest_word
);
  import sha_pkg::*;

  logic [31:0]  word_r;
  logic [2:0]   nb_r;
  logic         eom_r;
  logic [63:0]  bits_r;
  logic [511:0] blk_r;
  logic [31:0]  v_r [8];
  logic [31:0]  hash_r [8];

  logic [7:0]  push_byte;
  logic [2:0]  nb_clamp;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, e, a;

  // clamp byte count to four
  assign nb_clamp = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;

  // byte source select
  always_comb begin
    case (cmd.src)
      SRC_ITEM: push_byte = word_r[{~cmd.item_pos, 3'b000} +: 8];
      SRC_PAD:  push_byte = PAD_BYTE;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = bits_r[{~cmd.len_idx, 3'b000} +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  // message schedule taps
  assign w0    = blk_r[511:480];
  assign w1    = blk_r[479:448];
  assign w9    = blk_r[223:192];
  assign w14   = blk_r[63:32];
  assign w_new = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9
               + (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

  // one compression round
  assign e  = v_r[4];
  assign a  = v_r[0];
  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + K_TAB[cmd.round_idx] + w0;
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  // item capture and block shift line
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      word_r <= in_data.data_word;
      nb_r   <= nb_clamp;
      eom_r  <= in_data.end_of_message;
    end
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  // bit count
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      bits_r <= '0;
    end else if (cmd.load_item) begin
      bits_r <= bits_r + {58'd0, nb_clamp, 3'b000};
    end
  end

  // working variables and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= H_INIT[i];
        v_r[i]    <= H_INIT[i];
      end
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end else if (cmd.update) begin
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= hash_r[i] + v_r[i];
        v_r[i]    <= hash_r[i] + v_r[i];
      end
    end
  end

  assign sts.nb       = nb_r;
  assign sts.eom      = eom_r;
  assign digest_word  = hash_r[out_idx];

endmodule

### design/sha_ctrl.sv
// controller: byte sequencing, padding, round count and digest output
// depends on sha_pkg and sha256_stream_hash_defines.svh
`include "sha256_stream_hash_defines.svh"
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sha_pkg::sha_sts_t sts,
  output sha_pkg::sha_cmd_t cmd,
  output logic [2:0]        out_idx
);
  import sha_pkg::*;

  sha_state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0] pos_r;
  logic [5:0] fill_r;
  logic [2:0] lidx_r;
  logic [5:0] rnd_r;
  logic [2:0] oidx_r;
  logic       full;

  assign full = (fill_r == 6'd63);

  // next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_BYTES;
      end
      ST_BYTES: begin
        if (pos_r < sts.nb) begin
          if (full) begin
            state_nxt = ST_COMP;
            ret_nxt   = ST_BYTES;
          end
        end else begin
          state_nxt = sts.eom ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD: begin
        state_nxt = full ? ST_COMP : ST_ZERO;
        ret_nxt   = ST_ZERO;
      end
      ST_ZERO: begin
        if (fill_r == LEN_FILL) begin
          state_nxt = ST_LEN;
        end else if (full) begin
          state_nxt = ST_COMP;
          ret_nxt   = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (lidx_r == 3'd7) begin
          state_nxt = ST_COMP;
          ret_nxt   = ST_OUT;
        end
      end
      ST_COMP: begin
        if (rnd_r == 6'd63) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ret_r;
      end
      ST_OUT: begin
        if (out_ready && oidx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd           = '0;
    cmd.src       = SRC_ITEM;
    cmd.item_pos  = pos_r[1:0];
    cmd.len_idx   = lidx_r;
    cmd.round_idx = rnd_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_BYTES: cmd.push = (pos_r < sts.nb);
      ST_PAD: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_PAD;
      end
      ST_ZERO: begin
        cmd.push = (fill_r != LEN_FILL);
        cmd.src  = SRC_ZERO;
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.src  = SRC_LEN;
      end
      ST_COMP: cmd.round  = 1'b1;
      ST_UPD:  cmd.update = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready && (oidx_r == 3'd7);
      end
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      pos_r   <= '0;
      fill_r  <= '0;
      lidx_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      if (cmd.load_item) pos_r <= '0;
      else if (cmd.push && state_r == ST_BYTES) pos_r <= pos_r + 3'd1;
      if (cmd.push) fill_r <= fill_r + 6'd1;
      if (cmd.push && state_r == ST_LEN) lidx_r <= lidx_r + 3'd1;
      if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (out_valid && out_ready) oidx_r <= oidx_r + 3'd1;
    end
  end

  assign out_idx = oidx_r;

  `SHA_ASSERT(a_out_block_empty, clk, rst_n, (state_r == ST_OUT) |-> (fill_r == 6'd0), "digest shown with partial block")
  `SHA_ASSERT(a_round_end, clk, rst_n, (state_r == ST_COMP && rnd_r == 6'd63) |=> (state_r == ST_UPD), "rounds did not end in update")
  `SHA_ASSERT(a_len_fill, clk, rst_n, (state_r == ST_LEN) |-> (fill_r[5:3] == 3'b111), "length bytes out of place")
  `SHA_ASSERT_ALWAYS(a_busy_no_ready, clk, (in_ready && out_valid) |-> 1'b0, "input taken while digest pending")

endmodule

### design/sha256_stream_hash.sv
// channel  | signals                      | direction
// in       | in_valid in_ready in_data    | bytes of the message, item by item
// out      | out_valid out_ready out_data | eight digest words per message
//
// each item is accepted, then its valid bytes are pushed one by one, then closed.
// a full 64-byte block is compressed: 64 rounds on the single round unit
// and the chaining update.
// end of message pushes the pad, zero and length bytes (idle step before length),
// compresses each closed block and sends 8 digest words, one per accepted cycle.
// reset (rst_n low, synchronous) loads the initial hash and clears the counts.
// either side may stall at any time; one item is handled at a time.
// top level of the sha256 stream hash; depends on sha_pkg, sha_ctrl, sha_dp
module sha256_stream_hash (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  sha_cmd_t    cmd;
  sha_sts_t    sts;
  logic [2:0]  out_idx;
  logic [31:0] digest_word;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd, .out_idx
  );

  sha_dp u_dp (
    .clk, .rst_n, .in_data, .cmd, .out_idx, .sts, .digest_word
  );

  // result item
  assign out_data.digest_word = digest_word;
  assign out_data.word_index  = out_idx;
  assign out_data.last_word   = (out_idx == 3'd7);

endmodule
